@@ rtl/pmru_pkg.sv @@
// Package for the page map range unmapper: table geometry, opcodes, FSM states
// and the structs shared between the control, memory and top-level files.
// No dependencies.
package pmru_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_UNMAP = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0]  start_page;
    logic [7:0]  page_count;
    logic [15:0] displacement;
    logic [23:0] block_address;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    entry_t        wdata;
    logic          re;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

@@ rtl/pmru_if.sv @@
// Valid/ready channel interfaces for the page map range unmapper: the item
// channel and the result channel. No dependencies.
interface pmru_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  entry_index;
  logic [7:0]  start_page;
  logic [7:0]  page_count;
  logic [15:0] displacement;
  logic [23:0] block_address;
  logic        whole;

  modport source (
    output valid, opcode, entry_index, start_page, page_count, displacement,
           block_address, whole,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, start_page, page_count, displacement,
           block_address, whole,
    output ready
  );
endinterface

interface pmru_out_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic [7:0]  read_start_page;
  logic [7:0]  read_page_count;
  logic [15:0] read_displacement;
  logic [23:0] read_block_address;

  modport source (
    output valid, done_res, read_start_page, read_page_count, read_displacement,
           read_block_address,
    input  ready
  );
  modport sink (
    input  valid, done_res, read_start_page, read_page_count, read_displacement,
           read_block_address,
    output ready
  );
endinterface

@@ rtl/pmru_map_ram.sv @@
// Map entry memory: one write port, one read port, registered read data.
// Depends on pmru_pkg.
module pmru_map_ram (
  input  logic                clk_i,
  input  pmru_pkg::ram_req_t  req_i,
  output pmru_pkg::entry_t    rdata_o
);

  pmru_pkg::entry_t mem [pmru_pkg::MAX_ENTRIES];
  pmru_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pmru_trim.sv @@
// Entry trim logic: computes one map entry after unmapping a page range.
// Depends on pmru_pkg.
module pmru_trim (
  input  pmru_pkg::entry_t old_i,
  input  logic [7:0]       first_i,
  input  logic [7:0]       pages_i,
  input  logic             whole_i,
  output pmru_pkg::entry_t new_o
);

  logic [8:0] at9, end9, first9, rend9, shift9;
  logic       hit;

  always_comb begin
    at9    = {1'b0, old_i.start_page};
    end9   = at9 + {1'b0, old_i.page_count};
    first9 = {1'b0, first_i};
    rend9  = first9 + {1'b0, pages_i};
    shift9 = rend9 - at9;
    // skip empty entries and entries clear of the range
    hit    = (end9 != 9'd0) && (end9 > first9) && (at9 < rend9);
    new_o  = old_i;
    if (hit) begin
      if (whole_i) begin
        new_o.page_count = 8'd0;
      end else if (end9 <= rend9) begin
        // keep the head
        new_o.page_count = (first_i > old_i.start_page) ?
                           (first_i - old_i.start_page) : 8'd0;
      end else if (old_i.start_page >= first_i) begin
        // move the tail past the range
        new_o.start_page   = rend9[7:0];
        new_o.displacement = old_i.displacement + {7'd0, shift9};
        new_o.page_count   = old_i.page_count - shift9[7:0];
      end
    end
  end

endmodule

@@ rtl/pmru_ctrl.sv @@
// Control for the page map range unmapper: item capture, sequencer, unmap walk
// and result capture. Depends on pmru_pkg, pmru_if, pmru_trim.
module pmru_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  pmru_in_if.sink             in_if,
  input  logic [6:0]          entries_in_use_i,
  input  logic                out_free_i,
  output logic                res_push_o,
  output pmru_pkg::entry_t    res_o,
  output pmru_pkg::ram_req_t  ram_req_o,
  input  pmru_pkg::entry_t    ram_rdata_i
);

  localparam int unsigned AW = pmru_pkg::AW;
  localparam int unsigned CW = pmru_pkg::CW;

  pmru_pkg::state_e state_q, state_d;

  logic [1:0]       op_q;
  logic [5:0]       idx_q;
  logic             idx_ok_q;
  pmru_pkg::entry_t item_q;
  logic             whole_q;
  pmru_pkg::entry_t res_q;

  logic [CW-1:0]    rd_cnt_q, limit_q;
  logic             wb_vld_q;
  logic [AW-1:0]    wb_addr_q;

  logic             accept;
  logic             rd_en;
  logic [CW-1:0]    limit_d;
  logic             idx_ok_d;
  pmru_pkg::entry_t trimmed;

  assign accept = in_if.valid && in_if.ready;
  assign rd_en  = (rd_cnt_q < limit_q);

  always_comb begin
    if ({1'b0, entries_in_use_i} > 8'(pmru_pkg::MAX_ENTRIES)) begin
      limit_d = CW'(pmru_pkg::MAX_ENTRIES);
    end else begin
      limit_d = CW'(entries_in_use_i);
    end
    idx_ok_d = ({2'b00, in_if.entry_index} < 8'(pmru_pkg::MAX_ENTRIES));
  end

  pmru_trim u_trim (
    .old_i   (ram_rdata_i),
    .first_i (item_q.start_page),
    .pages_i (item_q.page_count),
    .whole_i (whole_q),
    .new_o   (trimmed)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmru_pkg::ST_IDLE: begin
        if (accept) begin
          case (pmru_pkg::opcode_e'(in_if.opcode))
            pmru_pkg::OP_WRITE: state_d = pmru_pkg::ST_WRITE;
            pmru_pkg::OP_UNMAP: state_d = pmru_pkg::ST_WALK;
            pmru_pkg::OP_READ:  state_d = pmru_pkg::ST_READ;
            default:            state_d = pmru_pkg::ST_DONE;
          endcase
        end
      end
      pmru_pkg::ST_WRITE:     state_d = pmru_pkg::ST_DONE;
      pmru_pkg::ST_READ:      state_d = pmru_pkg::ST_READ_WAIT;
      pmru_pkg::ST_READ_WAIT: state_d = pmru_pkg::ST_DONE;
      pmru_pkg::ST_WALK: begin
        if (!rd_en) begin
          state_d = pmru_pkg::ST_DONE;
        end
      end
      pmru_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = pmru_pkg::ST_IDLE;
        end
      end
      default: state_d = pmru_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_if.ready     = 1'b0;
    res_push_o      = 1'b0;
    ram_req_o       = '0;
    ram_req_o.wdata = item_q;
    case (state_q)
      pmru_pkg::ST_IDLE: in_if.ready = 1'b1;
      pmru_pkg::ST_WRITE: begin
        ram_req_o.we    = idx_ok_q;
        ram_req_o.waddr = AW'(idx_q);
      end
      pmru_pkg::ST_READ: begin
        ram_req_o.re    = idx_ok_q;
        ram_req_o.raddr = AW'(idx_q);
      end
      pmru_pkg::ST_WALK: begin
        // read the next entry while the previous one is written back
        ram_req_o.re    = rd_en;
        ram_req_o.raddr = rd_cnt_q[AW-1:0];
        ram_req_o.we    = wb_vld_q;
        ram_req_o.waddr = wb_addr_q;
        ram_req_o.wdata = trimmed;
      end
      pmru_pkg::ST_DONE: res_push_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pmru_pkg::ST_IDLE;
      wb_vld_q <= 1'b0;
      rd_cnt_q <= '0;
      limit_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        rd_cnt_q <= '0;
        limit_q  <= limit_d;
        wb_vld_q <= 1'b0;
      end else if (state_q == pmru_pkg::ST_WALK) begin
        wb_vld_q <= rd_en;
        if (rd_en) begin
          rd_cnt_q <= rd_cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q                 <= in_if.opcode;
      idx_q                <= in_if.entry_index;
      idx_ok_q             <= idx_ok_d;
      item_q.start_page    <= in_if.start_page;
      item_q.page_count    <= in_if.page_count;
      item_q.displacement  <= in_if.displacement;
      item_q.block_address <= in_if.block_address;
      whole_q              <= in_if.whole;
      res_q                <= '0;
    end else if (state_q == pmru_pkg::ST_READ_WAIT && idx_ok_q &&
                 pmru_pkg::opcode_e'(op_q) == pmru_pkg::OP_READ) begin
      res_q <= ram_rdata_i;
    end
    if (state_q == pmru_pkg::ST_WALK && rd_en) begin
      wb_addr_q <= rd_cnt_q[AW-1:0];
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/page_map_range_unmapper.sv @@
// Page map range unmapper top level: configuration register, output register
// and the map memory. Depends on pmru_pkg, pmru_if, pmru_map_ram, pmru_ctrl.

// The block holds 64 map entries of 56 bits in one synchronous memory with
// one write and one read port. One item is worked on at a time and every
// item gives one result. A write passes ST_WRITE, a read ST_READ and
// ST_READ_WAIT, and an unmap walks ST_WALK over the first n entries, where
// n is entries_in_use capped at 64: the walk reads one entry per cycle and
// writes the trimmed previous entry back in the same cycle, so the memory
// ports set the pace. Each item then waits in ST_DONE for a free output
// register, then the block returns to idle. The result sits in an output
// register, so a new item is taken while the last result still waits.
// Write entries_in_use only while no item is in flight. An entry that was
// never written reads as an undefined value.
module page_map_range_unmapper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  pmru_in_if.sink    in_if,
  pmru_out_if.source out_if
);

  logic [6:0]         entries_in_use_q;
  logic               out_valid_q;
  pmru_pkg::entry_t   out_q;
  logic               out_free;
  logic               res_push;
  pmru_pkg::entry_t   res;
  pmru_pkg::ram_req_t ram_req;
  pmru_pkg::entry_t   ram_rdata;

  // hold the walk length register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= '0;
    end else if (cfg_we_i) begin
      entries_in_use_q <= cfg_wdata_i;
    end
  end

  pmru_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_if            (in_if),
    .entries_in_use_i (entries_in_use_q),
    .out_free_i       (out_free),
    .res_push_o       (res_push),
    .res_o            (res),
    .ram_req_o        (ram_req),
    .ram_rdata_i      (ram_rdata)
  );

  pmru_map_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_if.valid              = out_valid_q;
  assign out_if.done_res           = 1'b1;
  assign out_if.read_start_page    = out_q.start_page;
  assign out_if.read_page_count    = out_q.page_count;
  assign out_if.read_displacement  = out_q.displacement;
  assign out_if.read_block_address = out_q.block_address;

`ifndef SYNTHESIS
  // the memory is written only while an item is being worked on
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> !in_if.ready)
    else $error("map memory written while idle");

  // a result is handed over only when the output register can take it
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> out_free)
    else $error("result pushed into a full output register");

  // a transfer on the item channel leaves the block busy
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("item taken while another is in flight");
`endif

endmodule

@@ test/tb_page_map_range_unmapper.sv @@
// Self-checking testbench for page_map_range_unmapper: directed and random
// table writes, reads and range unmaps checked against an in-bench predictor.
// Depends on pmru_pkg, pmru_if and the RTL of the block.
module tb_page_map_range_unmapper;
  timeunit 1ns;
  timeprecision 1ps;

  import pmru_pkg::*;

  // Opcode 3 has no enum member in the package; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // A full walk is 64 entries plus overhead; allow a margin on top.
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_ITEMS  = 110;
  localparam int unsigned HOLD_CYCLES  = 300;

  // One input item as the bench sees it.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  entry_index;
    logic [7:0]  start_page;
    logic [7:0]  page_count;
    logic [15:0] displacement;
    logic [23:0] block_address;
    logic        whole;
  } map_cmd_t;

  // One result item.
  typedef struct packed {
    logic        done;
    logic [7:0]  start_page;
    logic [7:0]  page_count;
    logic [15:0] displacement;
    logic [23:0] block_address;
  } map_reply_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  pmru_in_if  item_ch ();
  pmru_out_if result_ch ();

  page_map_range_unmapper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (item_ch),
    .out_if      (result_ch)
  );

  // Predictor state: a private copy of the table and of entries_in_use.
  entry_t     map_model [MAX_ENTRIES];
  logic [6:0] walk_cfg;
  map_reply_t pending_replies [$];

  int unsigned error_count;
  int unsigned sent_count;
  int unsigned unmap_count;
  int unsigned read_count;
  int unsigned checked_count;
  int unsigned cycle_count;
  int unsigned settings_seen;

  // Pacing controls shared between the test tasks and the channel processes.
  bit tx_gaps_on;
  bit rx_stalls_on;
  int tx_burst_left;
  int rx_hold_req;
  int rx_hold_left;
  int rx_run_left;
  bit rx_run_ready;

  // Clock: 12 ns period, high then low.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               pending_replies.size());
      $display("tb_page_map_range_unmapper: errors");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [23:0] got,
                             input logic [23:0] want);
    if (got !== want)
      report_error($sformatf("reply %0d %s: got 0x%0h, expected 0x%0h",
                             checked_count, name, got, want));
  endtask

  // Range unmap over the model table. Work in int so that the range end and
  // the entry end keep their carry bit, as the block's comparisons do.
  function automatic void apply_unmap(input logic [7:0] first_page,
                                      input logic [7:0] pages, input logic whole);
    int first;
    int range_end;
    int walk;
    int at;
    int len;
    int stop;
    int shift;
    first     = int'(first_page);
    range_end = first + int'(pages);
    walk      = int'(walk_cfg);
    // The walk never runs past the end of the table.
    if (walk > MAX_ENTRIES) walk = MAX_ENTRIES;
    for (int i = 0; i < walk; i++) begin
      at   = int'(map_model[i].start_page);
      len  = int'(map_model[i].page_count);
      stop = at + len;
      // Skip an empty entry (start and count both zero) and any entry
      // that misses the range.
      if (stop == 0 || stop <= first || at >= range_end) continue;
      if (whole) begin
        map_model[i].page_count = 8'd0;
        continue;
      end
      if (stop <= range_end) begin
        // Keep the head only; nothing left if the entry starts inside.
        map_model[i].page_count = (first > at) ? 8'(first - at) : 8'd0;
      end else if (at >= first) begin
        // Move the tail past the range and carry the shift into the
        // displacement; start page and displacement wrap.
        shift = range_end - at;
        map_model[i].start_page   = 8'(range_end);
        map_model[i].displacement = map_model[i].displacement + 16'(shift);
        map_model[i].page_count   = 8'(len - shift);
      end
      // An entry that strictly contains the range stays as it is.
    end
  endfunction

  function automatic map_reply_t predict_reply(input map_cmd_t c);
    map_reply_t r;
    r      = '0;
    r.done = 1'b1;
    case (c.opcode)
      OP_WRITE: begin
        if (c.entry_index < MAX_ENTRIES)
          map_model[c.entry_index] = '{c.start_page, c.page_count, c.displacement,
                                       c.block_address};
      end
      OP_UNMAP: begin
        apply_unmap(c.start_page, c.page_count, c.whole);
      end
      OP_READ: begin
        if (c.entry_index < MAX_ENTRIES) begin
          r.start_page    = map_model[c.entry_index].start_page;
          r.page_count    = map_model[c.entry_index].page_count;
          r.displacement  = map_model[c.entry_index].displacement;
          r.block_address = map_model[c.entry_index].block_address;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item and hold it until the transfer. In burst mode a random
  // gap is inserted whenever a burst runs out.
  task automatic send_item(input map_cmd_t c);
    int gap;
    @(negedge clk_i);
    if (tx_gaps_on) begin
      if (tx_burst_left == 0) begin
        gap = $urandom_range(1, 8);
        item_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
        tx_burst_left = $urandom_range(1, 12);
      end
      tx_burst_left--;
    end
    item_ch.opcode        = c.opcode;
    item_ch.entry_index   = c.entry_index;
    item_ch.start_page    = c.start_page;
    item_ch.page_count    = c.page_count;
    item_ch.displacement  = c.displacement;
    item_ch.block_address = c.block_address;
    item_ch.whole         = c.whole;
    item_ch.valid         = 1'b1;
    forever begin
      @(posedge clk_i);
      if (item_ch.ready) break;
    end
    pending_replies.push_back(predict_reply(c));
    sent_count++;
    if (c.opcode == OP_UNMAP) unmap_count++;
    if (c.opcode == OP_READ) read_count++;
  endtask

  // Drop valid and wait until every reply has arrived; the block is then idle.
  task automatic wait_for_replies();
    @(negedge clk_i);
    item_ch.valid = 1'b0;
    tx_burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_walk_length(input logic [6:0] n);
    wait_for_replies();
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = n;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    walk_cfg  = n;
    settings_seen++;
  endtask

  function automatic map_cmd_t make_cmd(input logic [1:0] op, input logic [5:0] idx,
                                        input logic [7:0] sp, input logic [7:0] pc,
                                        input logic [15:0] disp, input logic [23:0] blk,
                                        input logic whole);
    return '{op, idx, sp, pc, disp, blk, whole};
  endfunction

  // Random entry load: a few empty entries and zero counts, mostly short
  // entries so that ranges overlap in varied ways.
  function automatic map_cmd_t make_write(input logic [5:0] idx);
    map_cmd_t c;
    c               = '0;
    c.opcode        = OP_WRITE;
    c.entry_index   = idx;
    c.start_page    = 8'($urandom_range(0, 255));
    c.displacement  = 16'($urandom_range(0, 16'hFFFF));
    c.block_address = 24'($urandom_range(0, 24'hFFFFFF));
    c.whole         = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       begin c.start_page = 8'd0; c.page_count = 8'd0; end
      1:       c.page_count = 8'd0;
      2:       c.page_count = 8'($urandom_range(0, 255));
      default: c.page_count = 8'($urandom_range(1, 48));
    endcase
    return c;
  endfunction

  // Random unmap: half the ranges are placed near an existing entry.
  function automatic map_cmd_t make_unmap();
    map_cmd_t c;
    entry_t   anchor;
    c               = '0;
    c.opcode        = OP_UNMAP;
    c.entry_index   = 6'($urandom_range(0, 63));
    c.displacement  = 16'($urandom_range(0, 16'hFFFF));
    c.block_address = 24'($urandom_range(0, 24'hFFFFFF));
    c.whole         = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1)) begin
      anchor       = map_model[$urandom_range(0, MAX_ENTRIES - 1)];
      c.start_page = anchor.start_page + 8'($urandom_range(0, 32)) - 8'd16;
      c.page_count = 8'($urandom_range(0, 64));
    end else begin
      c.start_page = 8'($urandom_range(0, 255));
      c.page_count = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // Only called once every entry has been written.
  function automatic map_cmd_t make_random_item();
    int unsigned pick;
    map_cmd_t    c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c = make_write(6'($urandom_range(0, 63)));
    end else if (pick < 95 && pick >= 70) begin
      c = make_unmap();
    end else begin
      c = make_cmd(OP_READ, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 16'($urandom_range(0, 16'hFFFF)),
                   24'($urandom_range(0, 24'hFFFFFF)), 1'($urandom_range(0, 1)));
      if (pick >= 95) c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  // Check every reply against the oldest prediction.
  always @(posedge clk_i) begin : reply_check
    map_reply_t got;
    map_reply_t want;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.done_res, result_ch.read_start_page, result_ch.read_page_count,
              result_ch.read_displacement, result_ch.read_block_address};
      if (pending_replies.size() == 0) begin
        report_error("reply with no item waiting");
      end else begin
        want = pending_replies.pop_front();
        check_field("done_res", 24'(got.done), 24'(want.done));
        check_field("read_start_page", 24'(got.start_page), 24'(want.start_page));
        check_field("read_page_count", 24'(got.page_count), 24'(want.page_count));
        check_field("read_displacement", 24'(got.displacement), 24'(want.displacement));
        check_field("read_block_address", got.block_address, want.block_address);
        checked_count++;
      end
    end
  end

  // Result side pacing: a requested hold wins, otherwise random runs of
  // ready and stall, or always ready when stalls are off.
  always @(negedge clk_i) begin : result_pacing
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      result_ch.ready = 1'b0;
      rx_hold_left--;
    end else if (!rx_stalls_on) begin
      result_ch.ready = 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_run_ready = ($urandom_range(0, 9) < 6);
        rx_run_left  = $urandom_range(1, 6);
      end
      result_ch.ready = rx_run_ready;
      rx_run_left--;
    end
  end

  // Hand-picked entries and ranges: empty entry, zero count with a nonzero
  // start, head kept, tail moved with displacement wrap, range strictly
  // inside an entry, tail moved with the range end past page 255, whole
  // unmap, unused opcode and the field extremes.
  task automatic test_directed_cases();
    send_item(make_cmd(OP_WRITE, 6'd0, 8'd0, 8'd0, 16'h1234, 24'h000000, 1'b0));
    send_item(make_cmd(OP_WRITE, 6'd1, 8'd5, 8'd0, 16'h0001, 24'h000001, 1'b1));
    send_item(make_cmd(OP_WRITE, 6'd2, 8'd20, 8'd30, 16'h0000, 24'h123456, 1'b0));
    send_item(make_cmd(OP_WRITE, 6'd3, 8'd100, 8'd50, 16'hFFF0, 24'hABCDEF, 1'b0));
    send_item(make_cmd(OP_WRITE, 6'd4, 8'd200, 8'd50, 16'h8000, 24'h800000, 1'b0));
    send_item(make_cmd(OP_WRITE, 6'd5, 8'd200, 8'd255, 16'hFFFF, 24'h7FFFFF, 1'b0));
    send_item(make_cmd(OP_WRITE, 6'd6, 8'd255, 8'd255, 16'hFFFF, 24'hFFFFFF, 1'b1));
    // Unused opcode with every field at its top value: no effect.
    send_item(make_cmd(OP_UNUSED, 6'h3F, 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 1'b1));
    set_walk_length(7'd7);
    send_item(make_cmd(OP_UNMAP, 6'd0, 8'd0, 8'd10, 16'h0000, 24'h000000, 1'b0));
    send_item(make_cmd(OP_UNMAP, 6'd0, 8'd40, 8'd20, 16'h0000, 24'h000000, 1'b0));
    send_item(make_cmd(OP_UNMAP, 6'd0, 8'd90, 8'd30, 16'h0000, 24'h000000, 1'b0));
    send_item(make_cmd(OP_UNMAP, 6'd0, 8'd210, 8'd10, 16'h0000, 24'h000000, 1'b0));
    send_item(make_cmd(OP_UNMAP, 6'd0, 8'd150, 8'd120, 16'h0000, 24'h000000, 1'b0));
    for (int i = 0; i < 7; i++)
      send_item(make_cmd(OP_READ, 6'(i), 8'hFF, 8'hFF, 16'hFFFF, 24'hFFFFFF, 1'b0));
    send_item(make_cmd(OP_UNMAP, 6'h3F, 8'd0, 8'd255, 16'hFFFF, 24'hFFFFFF, 1'b1));
    send_item(make_cmd(OP_READ, 6'd2, 8'd0, 8'd0, 16'h0000, 24'h000000, 1'b0));
    send_item(make_cmd(OP_READ, 6'd6, 8'd0, 8'd0, 16'h0000, 24'h000000, 1'b0));
  endtask

  // Load every entry so that any later read or walk only sees written data.
  task automatic test_fill_table();
    for (int i = 0; i < MAX_ENTRIES; i++) send_item(make_write(6'(i)));
  endtask

  // Random traffic under several walk lengths: full table, one entry, a
  // value past the table, none, a random middle value and full again.
  // One phase runs with no idling on either side.
  task automatic test_random_phases();
    logic [6:0] walk_settings [6];
    walk_settings = '{7'd64, 7'd1, 7'd127, 7'd0, 7'($urandom_range(2, 63)), 7'd64};
    for (int p = 0; p < 6; p++) begin
      set_walk_length(walk_settings[p]);
      tx_gaps_on   = (p != 4);
      rx_stalls_on = (p != 4);
      repeat (PHASE_ITEMS) send_item(make_random_item());
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // Hold the result side off for a long stretch while items keep coming, so
  // that the output register fills and the block stalls its input.
  task automatic test_backpressure();
    set_walk_length(7'd64);
    tx_gaps_on  = 1'b0;
    rx_hold_req = HOLD_CYCLES;
    repeat (24) send_item(make_random_item());
    tx_gaps_on  = 1'b1;
  endtask

  initial begin
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    item_ch.valid         = 1'b0;
    item_ch.opcode        = '0;
    item_ch.entry_index   = '0;
    item_ch.start_page    = '0;
    item_ch.page_count    = '0;
    item_ch.displacement  = '0;
    item_ch.block_address = '0;
    item_ch.whole         = 1'b0;
    result_ch.ready       = 1'b0;
    walk_cfg              = '0;
    tx_gaps_on            = 1'b1;
    rx_stalls_on          = 1'b1;
    for (int i = 0; i < MAX_ENTRIES; i++) map_model[i] = '0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_fill_table();
    test_random_phases();
    test_backpressure();

    // Drain, then give the block time to show any stray reply.
    wait_for_replies();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_replies.size() != 0)
      report_error($sformatf("%0d replies never arrived", pending_replies.size()));

    $display("run covered %0d items (%0d unmaps, %0d reads) over %0d walk settings",
             sent_count, unmap_count, read_count, settings_seen);
    $display("%0d replies checked, %0d errors, %0d cycles", checked_count, error_count,
             cycle_count);
    if (error_count == 0) begin
      $display("tb_page_map_range_unmapper: clean");
    end else begin
      $display("tb_page_map_range_unmapper: errors");
    end
    $finish;
  end

endmodule

@@ page_map_range_unmapper.f @@
rtl/pmru_pkg.sv
rtl/pmru_if.sv
rtl/pmru_map_ram.sv
rtl/pmru_trim.sv
rtl/pmru_ctrl.sv
rtl/page_map_range_unmapper.sv
test/tb_page_map_range_unmapper.sv
